[rtl/gtr_pkg.sv]
// ----------------------------------------------------------------------------
// gtr_pkg: shared types, codes and the font table of the text renderer.
// Holds command codes, register indexes, the queued operation format and
// the 5x7 column font.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtr_pkg;

    // Scale values fit in five bits for any supported maximum scale.
    localparam int SCALE_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int ADVANCE_X  = 6;
    localparam int ADVANCE_Y  = 8;
    localparam logic [7:0] FIRST_CODE   = 8'd32;
    localparam logic [7:0] LAST_CODE    = 8'd126;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Input commands.
    localparam logic [1:0] CMD_BEGIN     = 2'd0;
    localparam logic [1:0] CMD_DRAW      = 2'd1;
    localparam logic [1:0] CMD_READ_FRAME = 2'd2;
    localparam logic [1:0] CMD_READ_MASK = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INK_BLACK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 3'd4;

    // Operations passed from the front end to the drawing engine.
    localparam logic [1:0] OP_DRAW       = 2'd0;
    localparam logic [1:0] OP_READ_FRAME = 2'd1;
    localparam logic [1:0] OP_READ_MASK  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [13:0] addr;
    } op_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic               ink;
        logic               mask_en;
    } cfg_t;

    // Font: five column bytes per glyph, first column in the top byte,
    // bit 0 of a column is the top row.
    localparam logic [39:0] GLYPH_ROM [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    // One column byte of a glyph; idx is the code minus the first code.
    function automatic logic [7:0] glyph_column(input logic [6:0] idx,
                                                input logic [2:0] col);
        logic [39:0] entry;
        entry = (idx <= 7'd94) ? GLYPH_ROM[idx] : 40'h0;
        return entry[(39 - 8 * int'(col)) -: 8];
    endfunction

    // Saturate an 18-bit signed value to the 16-bit signed range.
    function automatic logic [15:0] sat16(input logic [17:0] v);
        if ($signed(v) > $signed(18'sd32767))
            return 16'h7FFF;
        else if ($signed(v) < -$signed(18'sd32768))
            return 16'h8000;
        else
            return v[15:0];
    endfunction

endpackage

[rtl/gtr_ram.sv]
// ----------------------------------------------------------------------------
// gtr_ram: generic single-write, single-read RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/gtr_fifo.sv]
// ----------------------------------------------------------------------------
// gtr_fifo: two-entry operation queue.
// Decouples the command front end from the drawing engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtr_fifo
    import gtr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic op_valid,
    output op_t  head
);

    op_t        slot_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign head     = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && op_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[rtl/gtr_front.sv]
// ----------------------------------------------------------------------------
// gtr_front: command front end.
// Holds the registers and the cursor, accepts items, updates the cursor and
// queues draw and read operations for the drawing engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtr_front
    import gtr_pkg::*;
#(
    parameter int MAX_SCALE = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [1:0]            cmd,
    input  logic [7:0]            char_code,
    input  logic [13:0]           byte_address,
    output logic                  full,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  clearing,
    input  logic                  fifo_full,
    output logic                  enq,
    output op_t                   enq_op,
    output cfg_t                  cfg
);

    logic [10:0]        origin_x_reg, origin_y_reg;
    logic [3:0]         scale_reg;
    logic               ink_reg, mask_en_reg;
    logic [15:0]        cursor_x_reg, cursor_x_next;
    logic [15:0]        cursor_y_reg, cursor_y_next;
    logic [SCALE_W-1:0] eff_scale;
    logic               accept;
    logic               printable;
    logic [15:0]        origin_x_ext, origin_y_ext;

    assign full   = fifo_full || clearing;
    assign accept = push && !full;

    // Effective scale: zero reads as one, large values clamp to the maximum.
    always_comb
    begin
        if (scale_reg == 4'd0)
            eff_scale = SCALE_W'(1);
        else if (SCALE_W'(scale_reg) > SCALE_W'(MAX_SCALE))
            eff_scale = SCALE_W'(MAX_SCALE);
        else
            eff_scale = SCALE_W'(scale_reg);
    end

    assign cfg.scale   = eff_scale;
    assign cfg.ink     = ink_reg;
    assign cfg.mask_en = mask_en_reg;

    assign origin_x_ext = {{5{origin_x_reg[10]}}, origin_x_reg};
    assign origin_y_ext = {{5{origin_y_reg[10]}}, origin_y_reg};
    assign printable    = (char_code >= FIRST_CODE) && (char_code <= LAST_CODE);

    // Classify the item, move the cursor and build the queued operation.
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        enq           = 1'b0;
        enq_op.kind   = OP_DRAW;
        enq_op.code   = char_code;
        enq_op.cx     = cursor_x_reg;
        enq_op.cy     = cursor_y_reg;
        enq_op.addr   = byte_address;
        if (accept)
        begin
            unique case (cmd)
                CMD_BEGIN:
                begin
                    cursor_x_next = origin_x_ext;
                    cursor_y_next = origin_y_ext;
                end
                CMD_DRAW:
                begin
                    if (char_code == NEWLINE_CODE)
                    begin
                        cursor_x_next = origin_x_ext;
                        cursor_y_next = sat16({{2{cursor_y_reg[15]}}, cursor_y_reg}
                                              + 18'(eff_scale) * 18'(ADVANCE_Y));
                    end
                    else
                    begin
                        enq           = printable;
                        cursor_x_next = sat16({{2{cursor_x_reg[15]}}, cursor_x_reg}
                                              + 18'(eff_scale) * 18'(ADVANCE_X));
                    end
                end
                CMD_READ_FRAME:
                begin
                    enq         = 1'b1;
                    enq_op.kind = OP_READ_FRAME;
                end
                CMD_READ_MASK:
                begin
                    enq         = 1'b1;
                    enq_op.kind = OP_READ_MASK;
                end
                default:
                begin
                    enq = 1'b0;
                end
            endcase
        end
    end

    // Cursor registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= 16'd0;
            cursor_y_reg <= 16'd0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= 11'd0;
            origin_y_reg <= 11'd0;
            scale_reg    <= 4'd1;
            ink_reg      <= 1'b1;
            mask_en_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:    origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y:    origin_y_reg <= cfg_data;
                CFG_GLYPH_SCALE: scale_reg    <= cfg_data[3:0];
                CFG_INK_BLACK:   ink_reg      <= cfg_data[0];
                CFG_MASK_ENABLE: mask_en_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

endmodule

[rtl/gtr_engine.sv]
// ----------------------------------------------------------------------------
// gtr_engine: drawing engine.
// Clears both stores after reset, walks font dots and scaled pixels with a
// read-modify-write on the stores, and serves store reads into a result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtr_engine
    import gtr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 400,
    parameter int SCREEN_HEIGHT = 240,
    parameter int ROW_BYTES     = 52
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       op_valid,
    input  op_t        head,
    output logic       op_pop,
    output logic       clearing,
    input  logic       pop,
    output logic       out_valid,
    output logic [7:0] read_data
);

    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
    localparam int AW          = $clog2(STORE_BYTES);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DOT   = 3'd2;
    localparam logic [2:0] ST_PADDR = 3'd3;
    localparam logic [2:0] ST_PWR   = 3'd4;
    localparam logic [2:0] ST_RDATA = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [7:0]         code_reg, code_next;
    logic [15:0]        cx_reg, cx_next, cy_reg, cy_next;
    logic [2:0]         col_reg, col_next, row_reg, row_next;
    logic [SCALE_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [17:0]        px_reg, px_next, py_reg, py_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               rd_mask_reg, rd_mask_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         read_data_reg, read_data_next;

    logic               we_frame, we_mask;
    logic [AW-1:0]      waddr, raddr;
    logic [7:0]         wdata_frame, wdata_mask;
    logic [7:0]         rdata_frame, rdata_mask;
    logic [7:0]         col_byte, bit_mask;
    logic               dot_bit, pix_step, dot_step;
    logic               on_screen, idx_ok;
    logic [31:0]        idx_full, head_addr;

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    assign col_byte  = glyph_column(7'(code_reg - FIRST_CODE), col_reg);
    assign dot_bit   = col_byte[row_reg];
    assign bit_mask  = 8'h80 >> px_reg[2:0];
    assign head_addr = 32'(head.addr);

    // Clip to the screen and form the store byte index of the pixel.
    assign on_screen = ($signed(px_reg) >= 0) && ($signed(px_reg) < $signed(18'(SCREEN_WIDTH)))
                    && ($signed(py_reg) >= 0) && ($signed(py_reg) < $signed(18'(SCREEN_HEIGHT)));
    assign idx_full  = 32'(py_reg[9:0]) * 32'(ROW_BYTES) + 32'(px_reg[12:3]);
    assign idx_ok    = on_screen && (idx_full < 32'(STORE_BYTES));

    gtr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_frame (
        .clk   (clk),
        .we    (we_frame),
        .waddr (waddr),
        .wdata (wdata_frame),
        .raddr (raddr),
        .rdata (rdata_frame)
    );

    gtr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_mask (
        .clk   (clk),
        .we    (we_mask),
        .waddr (waddr),
        .wdata (wdata_mask),
        .raddr (raddr),
        .rdata (rdata_mask)
    );

    // Engine sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        code_next      = code_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        idx_next       = idx_reg;
        rd_mask_next   = rd_mask_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        op_pop         = 1'b0;
        we_frame       = 1'b0;
        we_mask        = 1'b0;
        waddr          = idx_reg;
        raddr          = idx_full[AW-1:0];
        wdata_frame    = cfg.ink ? (rdata_frame | bit_mask) : (rdata_frame & ~bit_mask);
        wdata_mask     = rdata_mask | bit_mask;
        pix_step       = 1'b0;
        dot_step       = 1'b0;

        // The result leaves when it is taken.
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                we_frame    = 1'b1;
                we_mask     = 1'b1;
                waddr       = clr_reg;
                wdata_frame = 8'd0;
                wdata_mask  = 8'd0;
                if (clr_reg == AW'(STORE_BYTES - 1))
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                raddr = head_addr[AW-1:0];
                if (op_valid)
                begin
                    if (head.kind == OP_DRAW)
                    begin
                        op_pop     = 1'b1;
                        code_next  = head.code;
                        cx_next    = head.cx;
                        cy_next    = head.cy;
                        col_next   = 3'd0;
                        row_next   = 3'd0;
                        dx_next    = '0;
                        dy_next    = '0;
                        state_next = ST_DOT;
                    end
                    else if (!out_valid_reg)
                    begin
                        op_pop       = 1'b1;
                        rd_mask_next = (head.kind == OP_READ_MASK);
                        rd_ok_next   = (head_addr < 32'(STORE_BYTES));
                        state_next   = ST_RDATA;
                    end
                end
            end
            ST_RDATA:
            begin
                out_valid_next = 1'b1;
                read_data_next = !rd_ok_reg ? 8'd0 : (rd_mask_reg ? rdata_mask : rdata_frame);
                state_next     = ST_IDLE;
            end
            ST_DOT:
            begin
                if (dot_bit)
                begin
                    px_next = {{2{cx_reg[15]}}, cx_reg} + 18'(col_reg) * 18'(cfg.scale)
                              + 18'(dx_reg);
                    py_next = {{2{cy_reg[15]}}, cy_reg} + 18'(row_reg) * 18'(cfg.scale)
                              + 18'(dy_reg);
                    state_next = ST_PADDR;
                end
                else
                begin
                    dot_step = 1'b1;
                end
            end
            ST_PADDR:
            begin
                if (idx_ok)
                begin
                    idx_next   = idx_full[AW-1:0];
                    state_next = ST_PWR;
                end
                else
                begin
                    pix_step = 1'b1;
                end
            end
            ST_PWR:
            begin
                we_frame = 1'b1;
                we_mask  = cfg.mask_en;
                pix_step = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Next scaled pixel of the current dot, then the next dot.
        if (pix_step)
        begin
            state_next = ST_DOT;
            if (dy_reg != cfg.scale - SCALE_W'(1))
            begin
                dy_next = dy_reg + SCALE_W'(1);
            end
            else
            begin
                dy_next = '0;
                if (dx_reg != cfg.scale - SCALE_W'(1))
                    dx_next = dx_reg + SCALE_W'(1);
                else
                begin
                    dx_next  = '0;
                    dot_step = 1'b1;
                end
            end
        end
        if (dot_step)
        begin
            state_next = ST_DOT;
            if (row_reg != 3'd6)
                row_next = row_reg + 3'd1;
            else
            begin
                row_next = 3'd0;
                if (col_reg != 3'd4)
                    col_next = col_reg + 3'd1;
                else
                    state_next = ST_IDLE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        idx_reg       <= idx_next;
        rd_mask_reg   <= rd_mask_next;
        rd_ok_reg     <= rd_ok_next;
        read_data_reg <= read_data_next;
    end

    // A store write follows its address stage.
    a_pwr_after_paddr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PWR) |-> ($past(state_reg) == ST_PADDR))
        else $error("pixel write without address stage");

    // No result appears during the clearing pass.
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid_reg)
        else $error("result while clearing");

    // Operations are taken only from a non-empty queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> op_valid)
        else $error("pop from empty queue");

    // A read result is loaded only when the result register was free.
    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDATA) |-> !out_valid_reg)
        else $error("result register overwritten");

endmodule

[rtl/glyph_text_renderer_5x7_top.sv]
// ----------------------------------------------------------------------------
// glyph_text_renderer_5x7_top: 5x7 bitmap font text renderer.
// Top level joining the command front end, the operation queue and the
// drawing engine.
// ----------------------------------------------------------------------------
// After reset the block clears all ROW_BYTES*SCREEN_HEIGHT bytes (12480 by
// default) of both stores, one byte of each per cycle, and holds full high
// meanwhile. Begin and newline items are handled in the front end and are
// not queued. A read passes from the head of the queue through the store's
// registered read and the result register to the result ports, and waits
// while an earlier result has not been taken. A printable character leaves
// the queue; the engine then steps over each clear font dot and takes each
// scaled pixel of a set dot through the dot, address and write states (the
// write is skipped when the pixel is off screen), a read-modify-write on the
// store. A two-entry queue lets new items enter while a glyph is drawn.
`timescale 1ns / 1ps

module glyph_text_renderer_5x7_top
    import gtr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 400,
    parameter int SCREEN_HEIGHT = 240,
    parameter int ROW_BYTES     = 52,
    parameter int MAX_SCALE     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            cmd,
    input  logic [7:0]            char_code,
    input  logic [13:0]           byte_address,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            read_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic clearing, fifo_full, enq, op_valid, op_pop, out_valid;
    op_t  enq_op, head;
    cfg_t cfg;

    assign empty = !out_valid;

    gtr_front #(.MAX_SCALE(MAX_SCALE)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .cmd          (cmd),
        .char_code    (char_code),
        .byte_address (byte_address),
        .full         (full),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .clearing     (clearing),
        .fifo_full    (fifo_full),
        .enq          (enq),
        .enq_op       (enq_op),
        .cfg          (cfg)
    );

    gtr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (enq),
        .push_op  (enq_op),
        .full     (fifo_full),
        .pop      (op_pop),
        .op_valid (op_valid),
        .head     (head)
    );

    gtr_engine #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ROW_BYTES     (ROW_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .op_valid  (op_valid),
        .head      (head),
        .op_pop    (op_pop),
        .clearing  (clearing),
        .pop       (pop),
        .out_valid (out_valid),
        .read_data (read_data)
    );

endmodule

[tb/tb_checker.sv]
// ----------------------------------------------------------------------------
// tb_checker: text renderer scoreboard.
// Watches the item and result channels and the register port, keeps its own
// copy of both stores, the cursor and the registers, and compares each read
// byte with the oldest predicted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_checker
    import gtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [1:0]            cmd,
    input  logic [7:0]            char_code,
    input  logic [13:0]           byte_address,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [7:0]            read_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    bytes_pending
);

    localparam int SCR_W       = 400;
    localparam int SCR_H       = 240;
    localparam int ROW_B       = 52;
    localparam int SCALE_LIMIT = 8;
    localparam int STORE_SIZE  = ROW_B * SCR_H;

    logic [7:0] frame_copy [STORE_SIZE];
    logic [7:0] mask_copy  [STORE_SIZE];
    int         pen_x, pen_y;
    int         org_x, org_y;
    int         scale_reg;
    bit         ink_reg, mask_reg;
    logic [7:0] read_bytes [$];

    // The 95 printable glyphs, five column bytes each, bit 0 on top.
    logic [39:0] font [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    assign bytes_pending = read_bytes.size();

    function automatic int clamp_cursor(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int active_scale();
        if (scale_reg < 1)
            return 1;
        if (scale_reg > SCALE_LIMIT)
            return SCALE_LIMIT;
        return scale_reg;
    endfunction

    // Write one pixel with the ink colour, clipped to the screen.
    task automatic paint_pixel(input int x, input int y);
        int         idx;
        logic [7:0] bitmask;
        if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H)
            return;
        idx = y * ROW_B + x / 8;
        bitmask = 8'h80 >> (x % 8);
        if (ink_reg)
            frame_copy[idx] = frame_copy[idx] | bitmask;
        else
            frame_copy[idx] = frame_copy[idx] & ~bitmask;
        if (mask_reg)
            mask_copy[idx] = mask_copy[idx] | bitmask;
    endtask

    task automatic render_glyph(input logic [7:0] code, input int s);
        logic [39:0] glyph;
        logic [7:0]  column;
        if (code < FIRST_CODE || code > LAST_CODE)
            return;
        glyph = font[code - FIRST_CODE];
        for (int c = 0; c < 5; c++)
        begin
            column = glyph[39 - 8 * c -: 8];
            for (int r = 0; r < 7; r++)
                if (column[r])
                    for (int dx = 0; dx < s; dx++)
                        for (int dy = 0; dy < s; dy++)
                            paint_pixel(pen_x + c * s + dx, pen_y + r * s + dy);
        end
    endtask

    // Apply one accepted item to the predicted state.
    task automatic apply_item(input logic [1:0] op, input logic [7:0] code,
                              input logic [13:0] addr);
        int s;
        s = active_scale();
        if (op == CMD_BEGIN)
        begin
            pen_x = org_x;
            pen_y = org_y;
        end
        else if (op == CMD_DRAW)
        begin
            if (code == NEWLINE_CODE)
            begin
                pen_x = org_x;
                pen_y = clamp_cursor(pen_y + ADVANCE_Y * s);
            end
            else
            begin
                render_glyph(code, s);
                pen_x = clamp_cursor(pen_x + ADVANCE_X * s);
            end
        end
        else if (addr >= STORE_SIZE)
            read_bytes.push_back(8'h00);
        else if (op == CMD_READ_FRAME)
            read_bytes.push_back(frame_copy[addr]);
        else
            read_bytes.push_back(mask_copy[addr]);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        foreach (frame_copy[i])
        begin
            frame_copy[i] = 8'h00;
            mask_copy[i]  = 8'h00;
        end
        pen_x = 0;
        pen_y = 0;
        org_x = 0;
        org_y = 0;
        scale_reg = 1;
        ink_reg = 1'b1;
        mask_reg = 1'b0;
    end

    // Sample every channel at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X:    org_x = $signed(cfg_data);
                    CFG_ORIGIN_Y:    org_y = $signed(cfg_data);
                    CFG_GLYPH_SCALE: scale_reg = int'(cfg_data[3:0]);
                    CFG_INK_BLACK:   ink_reg = cfg_data[0];
                    CFG_MASK_ENABLE: mask_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (read_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected read byte %02h", read_data));
                else
                begin
                    if (read_data !== read_bytes[0])
                        report_mismatch($sformatf("read_data %02h, predicted %02h",
                                                  read_data, read_bytes[0]));
                    void'(read_bytes.pop_front());
                end
            end
            if (push && !full)
                apply_item(cmd, char_code, byte_address);
        end
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: text renderer regression.
// Drives directed and random text, begin and read items through phases of
// register settings with random stalls on both sides, and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import gtr_pkg::*;

    localparam int CYCLE_LIMIT = 60000000;
    localparam int DRAIN_WAIT  = 300;
    localparam int STORE_SIZE  = 12480;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [1:0]            cmd = CMD_BEGIN;
    logic [7:0]            char_code = 8'h00;
    logic [13:0]           byte_address = 14'h0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            read_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ORIGIN_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    bytes_pending;
    int                    cycle_count = 0;
    bit                    calm = 1'b0;

    always #2 clk = ~clk;

    glyph_text_renderer_5x7_top DUT (.*);

    tb_checker u_checker (.*);

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random bursts of stall, none near the end.
    initial
    begin
        int gap;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 16);
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] code,
                             input logic [13:0] addr);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        push <= 1'b1;
        cmd <= op;
        char_code <= code;
        byte_address <= addr;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic idle_push();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Let the block finish drawing before registers change.
    task automatic settle();
        idle_push();
        while (bytes_pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_regs(input int ox, input int oy, input int s,
                            input bit ink, input bit msk);
        settle();
        write_reg(CFG_ORIGIN_X, ox[10:0]);
        write_reg(CFG_ORIGIN_Y, oy[10:0]);
        write_reg(CFG_GLYPH_SCALE, s[10:0]);
        write_reg(CFG_INK_BLACK, {10'b0, ink});
        write_reg(CFG_MASK_ENABLE, {10'b0, msk});
    endtask

    // A random read aimed mostly at the store, sometimes past its end.
    task automatic random_read();
        logic [13:0] addr;
        addr = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, STORE_SIZE - 1));
        send_item($urandom_range(0, 1) ? CMD_READ_FRAME : CMD_READ_MASK, 8'h00, addr);
    endtask

    // One line of random text followed by four reads in a random window of 40 bytes and one random read.
    task automatic random_line(input int len);
        int base;
        send_item(CMD_BEGIN, 8'($urandom), 14'($urandom));
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 19))
                0:       send_item(CMD_DRAW, NEWLINE_CODE, 14'($urandom));
                1:       send_item(CMD_DRAW, 8'($urandom), 14'($urandom));
                default: send_item(CMD_DRAW, 8'($urandom_range(32, 126)), 14'($urandom));
            endcase
        end
        base = $urandom_range(0, STORE_SIZE - 40);
        for (int i = 0; i < 4; i++)
            send_item($urandom_range(0, 1) ? CMD_READ_FRAME : CMD_READ_MASK, 8'h00,
                      14'(base + $urandom_range(0, 39)));
        random_read();
    endtask

    initial
    begin
        int sent;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: draw before begin, every code class, extremes of addresses.
        send_item(CMD_DRAW, "A", 14'h0);
        send_item(CMD_READ_FRAME, 8'h00, 14'd0);
        send_item(CMD_READ_MASK, 8'hFF, 14'd0);
        send_item(CMD_DRAW, 8'd0, 14'h3FFF);
        send_item(CMD_DRAW, 8'd255, 14'h0);
        send_item(CMD_DRAW, 8'd127, 14'h0);
        send_item(CMD_DRAW, 8'd31, 14'h0);
        send_item(CMD_DRAW, 8'd126, 14'h0);
        send_item(CMD_DRAW, 8'd32, 14'h0);
        send_item(CMD_DRAW, NEWLINE_CODE, 14'h0);
        send_item(CMD_DRAW, "#", 14'h0);
        send_item(CMD_READ_FRAME, 8'h00, 14'd8);
        send_item(CMD_READ_FRAME, 8'h00, 14'd12479);
        send_item(CMD_READ_FRAME, 8'h00, 14'd12480);
        send_item(CMD_READ_MASK, 8'h00, 14'h3FFF);

        // Mask on, clear ink, scale 0 treated as one, negative origin.
        set_regs(-3, -2, 0, 1'b0, 1'b1);
        send_item(CMD_BEGIN, 8'h00, 14'h0);
        send_item(CMD_DRAW, "#", 14'h0);
        send_item(CMD_READ_FRAME, 8'h00, 14'd0);
        send_item(CMD_READ_MASK, 8'h00, 14'd0);
        send_item(CMD_READ_MASK, 8'h00, 14'd52);

        // Bottom right corner at the largest scale, and scale above limit.
        set_regs(390, 230, 15, 1'b1, 1'b1);
        send_item(CMD_BEGIN, 8'h00, 14'h0);
        send_item(CMD_DRAW, 8'd127 - 8'd1, 14'h0);
        send_item(CMD_READ_FRAME, 8'h00, 14'd12479);
        send_item(CMD_READ_MASK, 8'h00, 14'd12479);

        // Saturate the cursor: many newlines and characters at scale 8.
        set_regs(1023, 1023, 8, 1'b1, 1'b0);
        send_item(CMD_BEGIN, 8'h00, 14'h0);
        for (int i = 0; i < 520; i++)
            send_item(CMD_DRAW, NEWLINE_CODE, 14'h0);
        for (int i = 0; i < 700; i++)
            send_item(CMD_DRAW, 8'd200, 14'h0);
        send_item(CMD_DRAW, "W", 14'h0);
        send_item(CMD_READ_FRAME, 8'h00, 14'd100);

        // Random phases over several settings, mostly small scales.
        sent = 0;
        while (sent < 200)
        begin
            set_regs($urandom_range(0, 9) == 0 ? int'($urandom_range(0, 2047)) - 1024
                                               : $urandom_range(0, 9) == 0 ? 1023
                                               : int'($urandom_range(0, 408)) - 8,
                     $urandom_range(0, 9) == 0 ? -1024 : int'($urandom_range(0, 248)) - 8,
                     $urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 2),
                     $urandom_range(0, 1), $urandom_range(0, 1));
            if (sent > 100)
                calm = 1'b1;
            for (int k = 0; k < 6; k++)
            begin
                random_line($urandom_range(2, 14));
                sent += 14;
            end
            for (int k = 0; k < 10; k++)
                random_read();
            sent += 10;
        end

        // Drain and give the verdict.
        idle_push();
        while (bytes_pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
